>>> hw/rtl/idl_pkg.sv
package idl_pkg;

   // Default sizes of the log and of the sample and time fields.
   localparam int LOG_DEPTH_DEF    = 64;
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int TIME_WIDTH_DEF   = 32;

   // Control and status register port.
   localparam int CSR_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 3;

   // Fixed widths of the action and result fields.
   localparam int ACTION_WIDTH = 2;
   localparam int KIND_WIDTH   = 3;
   localparam int LEVEL_WIDTH  = 2;
   localparam int DELTA_WIDTH  = 16;
   localparam int STAMP_WIDTH  = 32;
   localparam int INDEX_WIDTH  = 6;
   localparam int COUNT_WIDTH  = 7;

   // Register reset values.
   localparam logic [CSR_WIDTH-1:0] BASELINE_RST   = 16'd4096;
   localparam logic [CSR_WIDTH-1:0] IMPACT_THR_RST = 16'd1434;
   localparam logic [CSR_WIDTH-1:0] MEDIUM_THR_RST = 16'd2867;
   localparam logic [CSR_WIDTH-1:0] HIGH_THR_RST   = 16'd4915;
   localparam logic [CSR_WIDTH-1:0] COOLDOWN_RST   = 16'd500;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BASELINE   = 3'd0,
      CSR_IMPACT_THR = 3'd1,
      CSR_MEDIUM_THR = 3'd2,
      CSR_HIGH_THR   = 3'd3,
      CSR_COOLDOWN   = 3'd4
   } csr_index_type;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_SAMPLE = 2'd0,
      ACT_LIST   = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_QUIET   = 3'd0,
      KIND_IMPACT  = 3'd1,
      KIND_ENTRY   = 3'd2,
      KIND_CLEARED = 3'd3,
      KIND_EMPTY   = 3'd4
   } kind_type;

   typedef enum logic [LEVEL_WIDTH-1:0] {
      LEVEL_NONE   = 2'd0,
      LEVEL_LOW    = 2'd1,
      LEVEL_MEDIUM = 2'd2,
      LEVEL_HIGH   = 2'd3
   } level_type;

endpackage

>>> hw/rtl/idl_if.sv
// Request channel: one action with its sample payload per transaction.
interface idl_req_if
   import idl_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int TIME_WIDTH   = TIME_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic [ACTION_WIDTH-1:0]        action;
   logic signed [SAMPLE_WIDTH-1:0] accel_x;
   logic signed [SAMPLE_WIDTH-1:0] accel_y;
   logic signed [SAMPLE_WIDTH-1:0] accel_z;
   logic [TIME_WIDTH-1:0]          time_ms;

   modport source (output valid, action, accel_x, accel_y, accel_z, time_ms, input ready);
   modport sink (input valid, action, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

// Response channel: one result per transaction.
interface idl_rsp_if
   import idl_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic [KIND_WIDTH-1:0]  kind;
   logic [LEVEL_WIDTH-1:0] level;
   logic [DELTA_WIDTH-1:0] delta;
   logic [STAMP_WIDTH-1:0] stamp_ms;
   logic [INDEX_WIDTH-1:0] entry_index;
   logic [COUNT_WIDTH-1:0] event_count;
   logic                   last;

   modport source (output valid, kind, level, delta, stamp_ms, entry_index, event_count,
                   last, input ready);
   modport sink (input valid, kind, level, delta, stamp_ms, entry_index, event_count,
                 last, output ready);
endinterface

>>> hw/rtl/impact_detector_logger.sv
// Shock detector with an event log.
//
// Channels: req_bus carries one action per transaction (sample, list log,
// clear log); rsp_bus returns results, with last set on the final result of
// each request. The csr_ port writes the five 16-bit registers; the user is to
// write them only while the block is idle, which the block does not enforce.
//
// A request is taken only while the controller is idle. For a sample, the sum
// of squares is formed MSB first, one multiplier bit of each axis per cycle,
// then the square root is resolved one root bit per cycle. A list reads each
// log entry through the registered read port of the log memory, then emits
// it. Clear and an empty list answer with one result. An unused action is
// dropped.
//
// Reset empties the log, zeroes the last impact time and loads the register
// defaults. A single output register holds the result; while the receiver
// stalls, work proceeds until the next result is ready and then waits.
module impact_detector_logger
   import idl_pkg::*;
#(
   parameter int LOG_DEPTH    = LOG_DEPTH_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int TIME_WIDTH   = TIME_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   idl_req_if.sink                    req_bus,
   idl_rsp_if.source                  rsp_bus,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata
);

   localparam int SQW = 2 * SAMPLE_WIDTH;
   localparam int STW = $clog2(SAMPLE_WIDTH);
   localparam int CW  = $clog2(LOG_DEPTH + 1);
   localparam int IW  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int DW  = (SAMPLE_WIDTH > DELTA_WIDTH) ? SAMPLE_WIDTH : DELTA_WIDTH;
   localparam int EW  = TIME_WIDTH + DELTA_WIDTH + LEVEL_WIDTH;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_SQRT,
      S_DELTA,
      S_DECIDE,
      S_CLEAR,
      S_EMPTY,
      S_LIST_RD,
      S_LIST_EMIT
   } state_type;

   state_type state_ff;

   logic [CSR_WIDTH-1:0] baseline_ff, impact_thr_ff, medium_thr_ff, high_thr_ff, cooldown_ff;

   logic [SAMPLE_WIDTH-1:0] abs_x_ff, abs_y_ff, abs_z_ff;
   logic [SAMPLE_WIDTH-1:0] bit_x_ff, bit_y_ff, bit_z_ff;
   logic [SQW-1:0]          acc_ff;
   logic [SAMPLE_WIDTH:0]   rem_ff;
   logic [SAMPLE_WIDTH-1:0] root_ff;
   logic [STW-1:0]          step_ff;
   logic [TIME_WIDTH-1:0]   time_ff;
   logic [DELTA_WIDTH-1:0]  delta_ff;

   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         idx_ff;
   logic [TIME_WIDTH-1:0] last_impact_ff;

   logic [EW-1:0] log_mem [LOG_DEPTH];
   logic [EW-1:0] rd_data_ff;

   logic                   rsp_valid_ff;
   logic [KIND_WIDTH-1:0]  rsp_kind_ff;
   logic [LEVEL_WIDTH-1:0] rsp_level_ff;
   logic [DELTA_WIDTH-1:0] rsp_delta_ff;
   logic [STAMP_WIDTH-1:0] rsp_stamp_ff;
   logic [INDEX_WIDTH-1:0] rsp_index_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;
   logic                   rsp_last_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff   <= BASELINE_RST;
         impact_thr_ff <= IMPACT_THR_RST;
         medium_thr_ff <= MEDIUM_THR_RST;
         high_thr_ff   <= HIGH_THR_RST;
         cooldown_ff   <= COOLDOWN_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BASELINE:   baseline_ff   <= csr_wdata;
            CSR_IMPACT_THR: impact_thr_ff <= csr_wdata;
            CSR_MEDIUM_THR: medium_thr_ff <= csr_wdata;
            CSR_HIGH_THR:   high_thr_ff   <= csr_wdata;
            CSR_COOLDOWN:   cooldown_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake helpers.
   logic req_accept;
   logic slot_free;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;

   // Magnitudes of the incoming sample.
   logic [SAMPLE_WIDTH-1:0] req_abs_x, req_abs_y, req_abs_z;

   assign req_abs_x = req_bus.accel_x[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-req_bus.accel_x)
                                                      : SAMPLE_WIDTH'(req_bus.accel_x);
   assign req_abs_y = req_bus.accel_y[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-req_bus.accel_y)
                                                      : SAMPLE_WIDTH'(req_bus.accel_y);
   assign req_abs_z = req_bus.accel_z[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-req_bus.accel_z)
                                                      : SAMPLE_WIDTH'(req_bus.accel_z);

   // One Horner step of the sum of squares: one multiplier bit of each axis.
   logic [SAMPLE_WIDTH+1:0] mul_term;
   logic [SQW-1:0]          acc_mul_in;

   assign mul_term = (bit_x_ff[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH+2)'(abs_x_ff) : '0)
                   + (bit_y_ff[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH+2)'(abs_y_ff) : '0)
                   + (bit_z_ff[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH+2)'(abs_z_ff) : '0);
   assign acc_mul_in = (acc_ff << 1) + SQW'(mul_term);

   // One restoring square root step: two radicand bits in, one root bit out.
   logic [SAMPLE_WIDTH+2:0] rem_trial;
   logic [SAMPLE_WIDTH+2:0] root_trial;
   logic                    root_bit;
   logic [SAMPLE_WIDTH:0]   rem_in;

   assign rem_trial  = {rem_ff, acc_ff[SQW-1 -: 2]};
   assign root_trial = {1'b0, root_ff, 2'b01};
   assign root_bit   = (rem_trial >= root_trial);
   assign rem_in     = root_bit ? (SAMPLE_WIDTH+1)'(rem_trial - root_trial)
                                : (SAMPLE_WIDTH+1)'(rem_trial);

   // Deviation from the resting magnitude, saturated to the delta width.
   logic [DW-1:0]          mag_ext, base_ext, diff;
   logic [DELTA_WIDTH-1:0] delta_in;

   assign mag_ext  = DW'(root_ff);
   assign base_ext = DW'(baseline_ff);
   assign diff     = (mag_ext >= base_ext) ? (mag_ext - base_ext) : (base_ext - mag_ext);
   assign delta_in = (|(diff >> DELTA_WIDTH)) ? '1 : DELTA_WIDTH'(diff);

   // Impact decision and grading.
   logic [TIME_WIDTH-1:0]  since;
   logic                   impact;
   logic                   log_room;
   logic                   log_we;
   logic [CW-1:0]          count_after;
   logic [LEVEL_WIDTH-1:0] grade;

   assign since       = time_ff - last_impact_ff;
   assign impact      = (delta_ff >= impact_thr_ff) && (since >= TIME_WIDTH'(cooldown_ff));
   assign log_room    = (count_ff < CW'(LOG_DEPTH));
   assign log_we      = (state_ff == S_DECIDE) && slot_free && impact && log_room;
   assign count_after = (impact && log_room) ? CW'(count_ff + 1'b1) : count_ff;
   assign grade       = (delta_ff >= high_thr_ff)   ? LEVEL_HIGH :
                        (delta_ff >= medium_thr_ff) ? LEVEL_MEDIUM : LEVEL_LOW;

   // Fields of the log entry being read out.
   logic [TIME_WIDTH-1:0]  rd_stamp;
   logic [DELTA_WIDTH-1:0] rd_delta;
   logic [LEVEL_WIDTH-1:0] rd_level;
   logic                   list_last;

   assign {rd_stamp, rd_delta, rd_level} = rd_data_ff;
   assign list_last = (CW'(idx_ff + 1'b1) == count_ff);

   // Log memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (log_we) begin
         log_mem[count_ff[IW-1:0]] <= {time_ff, delta_ff, grade};
      end
      if (state_ff == S_LIST_RD) begin
         rd_data_ff <= log_mem[idx_ff[IW-1:0]];
      end
   end

   // Arithmetic datapath.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            abs_x_ff <= req_abs_x;
            abs_y_ff <= req_abs_y;
            abs_z_ff <= req_abs_z;
            bit_x_ff <= req_abs_x;
            bit_y_ff <= req_abs_y;
            bit_z_ff <= req_abs_z;
            acc_ff   <= '0;
            step_ff  <= STW'(SAMPLE_WIDTH - 1);
            time_ff  <= req_bus.time_ms;
         end
         S_MUL: begin
            acc_ff   <= acc_mul_in;
            bit_x_ff <= bit_x_ff << 1;
            bit_y_ff <= bit_y_ff << 1;
            bit_z_ff <= bit_z_ff << 1;
            rem_ff   <= '0;
            root_ff  <= '0;
            step_ff  <= (step_ff == '0) ? STW'(SAMPLE_WIDTH - 1) : STW'(step_ff - 1'b1);
         end
         S_SQRT: begin
            acc_ff  <= acc_ff << 2;
            rem_ff  <= rem_in;
            root_ff <= {root_ff[SAMPLE_WIDTH-2:0], root_bit};
            step_ff <= STW'(step_ff - 1'b1);
         end
         S_DELTA: begin
            delta_ff <= delta_in;
         end
         default: ;
      endcase
   end

   // Controller, log bookkeeping and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         count_ff       <= '0;
         idx_ff         <= '0;
         last_impact_ff <= '0;
      end else begin
         if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  case (req_bus.action)
                     ACT_SAMPLE: state_ff <= S_MUL;
                     ACT_LIST: begin
                        idx_ff   <= '0;
                        state_ff <= (count_ff == '0) ? S_EMPTY : S_LIST_RD;
                     end
                     ACT_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= S_CLEAR;
                     end
                     default: ;
                  endcase
               end
            end
            S_MUL: begin
               if (step_ff == '0) begin
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (step_ff == '0) begin
                  state_ff <= S_DELTA;
               end
            end
            S_DELTA: state_ff <= S_DECIDE;
            S_DECIDE: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_delta_ff <= delta_ff;
                  rsp_index_ff <= '0;
                  rsp_count_ff <= COUNT_WIDTH'(count_after);
                  rsp_last_ff  <= 1'b1;
                  if (impact) begin
                     rsp_kind_ff    <= KIND_IMPACT;
                     rsp_level_ff   <= grade;
                     rsp_stamp_ff   <= STAMP_WIDTH'(time_ff);
                     last_impact_ff <= time_ff;
                  end else begin
                     rsp_kind_ff  <= KIND_QUIET;
                     rsp_level_ff <= LEVEL_NONE;
                     rsp_stamp_ff <= '0;
                  end
                  count_ff <= count_after;
                  state_ff <= S_IDLE;
               end
            end
            S_CLEAR, S_EMPTY: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= (state_ff == S_CLEAR) ? KIND_CLEARED : KIND_EMPTY;
                  rsp_level_ff <= LEVEL_NONE;
                  rsp_delta_ff <= '0;
                  rsp_stamp_ff <= '0;
                  rsp_index_ff <= '0;
                  rsp_count_ff <= '0;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_LIST_RD: state_ff <= S_LIST_EMIT;
            S_LIST_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= KIND_ENTRY;
                  rsp_level_ff <= rd_level;
                  rsp_delta_ff <= rd_delta;
                  rsp_stamp_ff <= STAMP_WIDTH'(rd_stamp);
                  rsp_index_ff <= INDEX_WIDTH'(idx_ff);
                  rsp_count_ff <= COUNT_WIDTH'(count_ff);
                  rsp_last_ff  <= list_last;
                  idx_ff       <= CW'(idx_ff + 1'b1);
                  state_ff     <= list_last ? S_IDLE : S_LIST_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Response channel drive.
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.kind        = rsp_kind_ff;
   assign rsp_bus.level       = rsp_level_ff;
   assign rsp_bus.delta       = rsp_delta_ff;
   assign rsp_bus.stamp_ms    = rsp_stamp_ff;
   assign rsp_bus.entry_index = rsp_index_ff;
   assign rsp_bus.event_count = rsp_count_ff;
   assign rsp_bus.last        = rsp_last_ff;

   // The log never holds more entries than it has room for.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(LOG_DEPTH))
      else $error("log count exceeds depth");

   // A clear transaction empties the log in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_bus.action == ACT_CLEAR) |=> count_ff == '0)
      else $error("clear did not empty the log");

   // The list walk reads only entries that have been written.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST_RD) |-> (idx_ff < count_ff))
      else $error("list walk read beyond the stored entries");

endmodule

>>> sim/shock_log_checker.sv
`timescale 1ns / 100ps

// Watches the request, result and register write ports of the shock detector,
// predicts the results of every accepted request and compares them in order.
module shock_log_checker
   import idl_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   idl_req_if                         req_mon,
   idl_rsp_if                         rsp_mon,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata,
   output int                         fault_count,
   output int                         results_awaited
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      kind_type               kind;
      level_type              level;
      logic [DELTA_WIDTH-1:0] delta;
      logic [STAMP_WIDTH-1:0] stamp;
      logic [INDEX_WIDTH-1:0] entry;
      logic [COUNT_WIDTH-1:0] count;
      logic                   last;
   } shock_result_t;

   typedef struct packed {
      logic [STAMP_WIDTH-1:0] stamp;
      logic [DELTA_WIDTH-1:0] delta;
      level_type              level;
   } shock_record_t;

   // Own copy of the registers and of the event log.
   logic [CSR_WIDTH-1:0]   baseline;
   logic [CSR_WIDTH-1:0]   impact_thr;
   logic [CSR_WIDTH-1:0]   medium_thr;
   logic [CSR_WIDTH-1:0]   high_thr;
   logic [CSR_WIDTH-1:0]   cooldown;
   logic [STAMP_WIDTH-1:0] last_impact;
   shock_record_t          event_log [LOG_DEPTH_DEF];
   int                     logged;
   shock_result_t          pending_results [$];
   int                     faults;

   function automatic longint unsigned square_of(input logic signed [SAMPLE_WIDTH_DEF-1:0] v);
      int m;
      m = v;
      if (m < 0) m = -m;
      return longint'(m) * longint'(m);
   endfunction

   // Floor square root, one root bit per step from the top.
   function automatic logic [16:0] floor_root(input longint unsigned n);
      logic [16:0]       root;
      longint unsigned   trial;
      root = '0;
      for (int b = 16; b >= 0; b--) begin
         trial = root | (17'd1 << b);
         if (trial * trial <= n) root = trial[16:0];
      end
      return root;
   endfunction

   function automatic string describe(input shock_result_t r);
      return $sformatf("kind %0d level %0d delta %0d stamp %h index %0d count %0d last %0b",
                       r.kind, r.level, r.delta, r.stamp, r.entry, r.count, r.last);
   endfunction

   // Works out the results that one request transaction causes.
   task automatic predict_results(input logic [ACTION_WIDTH-1:0] act,
                                  input logic signed [SAMPLE_WIDTH_DEF-1:0] ax, ay, az,
                                  input logic [STAMP_WIDTH-1:0] now);
      shock_result_t         res;
      longint unsigned       energy;
      logic [16:0]           mag;
      logic [16:0]           offset;
      logic [DELTA_WIDTH-1:0] dev;
      logic [STAMP_WIDTH-1:0] elapsed;
      level_type             grade;
      res = '0;
      res.last = 1'b1;
      case (act)
         ACT_SAMPLE: begin
            energy = square_of(ax) + square_of(ay) + square_of(az);
            mag = floor_root(energy);
            offset = (mag >= {1'b0, baseline}) ? mag - {1'b0, baseline}
                                               : {1'b0, baseline} - mag;
            dev = offset[16] ? 16'hFFFF : offset[15:0];
            elapsed = now - last_impact;
            res.delta = dev;
            if (dev >= impact_thr && elapsed >= {16'd0, cooldown}) begin
               if (dev >= high_thr) begin
                  grade = LEVEL_HIGH;
               end else if (dev >= medium_thr) begin
                  grade = LEVEL_MEDIUM;
               end else begin
                  grade = LEVEL_LOW;
               end
               last_impact = now;
               // A full log drops the impact but still reports it.
               if (logged < LOG_DEPTH_DEF) begin
                  event_log[logged] = '{stamp: now, delta: dev, level: grade};
                  logged++;
               end
               res.kind = KIND_IMPACT;
               res.level = grade;
               res.stamp = now;
            end else begin
               res.kind = KIND_QUIET;
            end
            res.count = 7'(logged);
            pending_results.push_back(res);
         end
         ACT_LIST: begin
            if (logged == 0) begin
               res.kind = KIND_EMPTY;
               pending_results.push_back(res);
            end else begin
               for (int i = 0; i < logged; i++) begin
                  res.kind = KIND_ENTRY;
                  res.level = event_log[i].level;
                  res.delta = event_log[i].delta;
                  res.stamp = event_log[i].stamp;
                  res.entry = 6'(i);
                  res.count = 7'(logged);
                  res.last = (i == logged - 1);
                  pending_results.push_back(res);
               end
            end
         end
         ACT_CLEAR: begin
            logged = 0;
            res.kind = KIND_CLEARED;
            pending_results.push_back(res);
         end
         default: begin
            // The unused action leaves no trace.
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      shock_result_t seen;
      shock_result_t want;
      if (reset) begin
         baseline = BASELINE_RST;
         impact_thr = IMPACT_THR_RST;
         medium_thr = MEDIUM_THR_RST;
         high_thr = HIGH_THR_RST;
         cooldown = COOLDOWN_RST;
         last_impact = '0;
         logged = 0;
         pending_results.delete();
      end else begin
         // Register writes land only while the block is idle.
         if (csr_wr_en) begin
            case (csr_index)
               CSR_BASELINE:   baseline = csr_wdata;
               CSR_IMPACT_THR: impact_thr = csr_wdata;
               CSR_MEDIUM_THR: medium_thr = csr_wdata;
               CSR_HIGH_THR:   high_thr = csr_wdata;
               CSR_COOLDOWN:   cooldown = csr_wdata;
               default: ;
            endcase
         end

         // Compare each result transaction with the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.kind = kind_type'(rsp_mon.kind);
            seen.level = level_type'(rsp_mon.level);
            seen.delta = rsp_mon.delta;
            seen.stamp = rsp_mon.stamp_ms;
            seen.entry = rsp_mon.entry_index;
            seen.count = rsp_mon.event_count;
            seen.last = rsp_mon.last;
            if (pending_results.size() == 0) begin
               faults++;
               if (faults <= REPORT_LIMIT)
                  $display("%0t: result with nothing expected: %s", $realtime, describe(seen));
            end else begin
               want = pending_results.pop_front();
               if (seen.kind !== want.kind || seen.level !== want.level ||
                   seen.delta !== want.delta || seen.stamp !== want.stamp ||
                   seen.entry !== want.entry || seen.count !== want.count ||
                   seen.last !== want.last) begin
                  faults++;
                  if (faults <= REPORT_LIMIT) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(seen));
                  end
               end
            end
         end

         if (req_mon.valid && req_mon.ready)
            predict_results(req_mon.action, req_mon.accel_x, req_mon.accel_y, req_mon.accel_z,
                            req_mon.time_ms);
      end
      results_awaited <= pending_results.size();
      fault_count <= faults;
   end

endmodule

>>> sim/impact_detector_logger_test.sv
`timescale 1ns / 100ps

// Drives the shock detector with directed and random requests under random
// sender gaps and receiver stalls, and gives the verdict.
module impact_detector_logger_test
   import idl_pkg::*;
;

   localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 60;
   localparam int STALL_LIMIT   = 3000;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_TRICKLE
   } rx_mode_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   csr_index_type        csr_index;
   logic [CSR_WIDTH-1:0] csr_wdata;
   int                   fault_count;
   int                   results_awaited;

   idl_req_if req_bus ();
   idl_rsp_if rsp_bus ();

   // Sender and receiver bookkeeping.
   int          burst_left;
   int          baseline_now;
   int          cooldown_now;
   logic [31:0] now_ms;
   rx_mode_type rx_mode;
   int          rx_left;
   int          quiet_cycles;

   impact_detector_logger u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   shock_log_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fault_count     (fault_count),
      .results_awaited (results_awaited)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver switches between always ready, coin-flip stalls and long stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_mode <= RX_OPEN;
         rx_left <= 0;
      end else begin
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 2));
            rx_left <= $urandom_range(20, 200);
         end else begin
            rx_left <= rx_left - 1;
         end
         case (rx_mode)
            RX_OPEN:  rsp_bus.ready <= 1'b1;
            RX_COIN:  rsp_bus.ready <= 1'($urandom_range(0, 1));
            default:  rsp_bus.ready <= (rx_left % 7 == 0);
         endcase
      end
   end

   // Ends the run when no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one request and holds it until the transaction completes.
   task automatic send_request(input logic [ACTION_WIDTH-1:0] act,
                               input logic [15:0] x, y, z, input logic [31:0] stamp);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.accel_x <= x;
      req_bus.accel_y <= y;
      req_bus.accel_z <= z;
      req_bus.time_ms <= stamp;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Lets every predicted result drain, then waits out any dropped request.
   task automatic settle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (results_awaited != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_WIDTH-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic reconfigure(input int base, imp, med, hi, cool);
      settle();
      write_register(CSR_BASELINE, 16'(base));
      write_register(CSR_IMPACT_THR, 16'(imp));
      write_register(CSR_MEDIUM_THR, 16'(med));
      write_register(CSR_HIGH_THR, 16'(hi));
      write_register(CSR_COOLDOWN, 16'(cool));
      csr_wr_en <= 1'b0;
      baseline_now = base;
      cooldown_now = cool;
   endtask

   // Mostly readings whose magnitude lies near the baseline, some fully random, some zero.
   task automatic send_reading();
      logic [15:0] axis [3];
      int          target;
      int          lead;
      case ($urandom_range(0, 15))
         0: axis = '{16'h0000, 16'h0000, 16'h0000};
         1, 2, 3, 4: axis = '{16'($urandom), 16'($urandom), 16'($urandom)};
         default: begin
            target = baseline_now + int'($urandom_range(0, 14000)) - 7000;
            if (target < 0) target = 0;
            if (target > 32767) target = 32767;
            if ($urandom_range(0, 1) == 1) target = -target;
            for (int i = 0; i < 3; i++) axis[i] = 16'(int'($urandom_range(0, 128)) - 64);
            lead = $urandom_range(0, 2);
            axis[lead] = 16'(target);
         end
      endcase
      case ($urandom_range(0, 9))
         0:       now_ms = $urandom;
         1, 2:    now_ms += $urandom_range(0, cooldown_now);
         default: now_ms += cooldown_now + $urandom_range(0, 300);
      endcase
      send_request(ACT_SAMPLE, axis[0], axis[1], axis[2], now_ms);
   endtask

   task automatic run_phase(input int items, input int list_pct, input int clear_pct);
      int pick;
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < list_pct)
            send_request(ACT_LIST, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
         else if (pick < list_pct + clear_pct)
            send_request(ACT_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
         else if (pick < list_pct + clear_pct + 3)
            send_request(ACT_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
         else
            send_reading();
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_BASELINE;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_SAMPLE;
      req_bus.accel_x = '0;
      req_bus.accel_y = '0;
      req_bus.accel_z = '0;
      req_bus.time_ms = '0;
      burst_left = 0;
      baseline_now = BASELINE_RST;
      cooldown_now = COOLDOWN_RST;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the register defaults from reset.
      send_request(ACT_LIST, 16'h0000, 16'h0000, 16'h0000, 32'd0);
      send_request(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 32'd0);
      send_request(ACT_SAMPLE, 16'd0, 16'd0, 16'd4096, 32'd0);
      // A large shock before the cooldown has run out since time zero.
      send_request(ACT_SAMPLE, 16'h7FFF, 16'd0, 16'd0, 32'd499);
      send_request(ACT_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 32'd500);
      send_request(ACT_SAMPLE, 16'd0, 16'd0, 16'h8000, 32'd900);
      // Deltas on either side of the impact and medium thresholds, and at the high one.
      send_request(ACT_SAMPLE, 16'd5530, 16'd0, 16'd0, 32'd1000);
      send_request(ACT_SAMPLE, 16'd0, 16'd5529, 16'd0, 32'd2000);
      send_request(ACT_SAMPLE, 16'd0, 16'd0, 16'd6963, 32'd3000);
      send_request(ACT_SAMPLE, 16'd0, 16'd0, 16'd6962, 32'd4000);
      send_request(ACT_SAMPLE, 16'd9011, 16'd0, 16'd0, 32'd5000);
      send_request(ACT_SAMPLE, 16'd0, 16'd0, 16'd0, 32'd6000);
      send_request(ACT_SAMPLE, 16'd2662, 16'd0, 16'd0, 32'd7000);
      send_request(ACT_SAMPLE, 16'd3000, -16'sd4000, 16'd0, 32'd8000);
      // Time wrapping around the top of its range.
      send_request(ACT_SAMPLE, 16'd12345, -16'sd2345, 16'd345, 32'hFFFF_FFFF);
      send_request(ACT_SAMPLE, 16'd0, 16'd0, 16'h8000, 32'h0000_0100);
      send_request(ACT_SAMPLE, 16'd0, 16'd0, 16'h8000, 32'h0000_01F3);
      send_request(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_request(ACT_LIST, 16'h0000, 16'h0000, 16'h0000, 32'd0);
      send_request(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 32'd0);
      send_request(ACT_LIST, 16'h0000, 16'h0000, 16'h0000, 32'd0);
      now_ms = 32'h0001_0000;

      // Random part over several register settings.
      reconfigure(4096, 1434, 2867, 4915, 500);
      run_phase(60, 6, 4);
      // Every reading is an impact, so the log overflows.
      reconfigure(0, 0, 0, 0, 0);
      run_phase(90, 3, 0);
      send_request(ACT_LIST, 16'h0000, 16'h0000, 16'h0000, 32'd0);
      send_request(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 32'd0);
      reconfigure(65535, 65535, 65535, 65535, 65535);
      run_phase(40, 5, 3);
      // Grading thresholds out of order.
      reconfigure(3000, 500, 6000, 2000, 20);
      run_phase(70, 6, 5);
      reconfigure($urandom_range(2000, 12000), $urandom_range(0, 9000),
                  $urandom_range(0, 12000), $urandom_range(0, 12000), $urandom_range(0, 2000));
      run_phase(70, 6, 5);
      reconfigure(4096, 1434, 2867, 4915, 500);
      run_phase(30, 6, 4);

      settle();
      if (fault_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/idl_pkg.sv
hw/rtl/idl_if.sv
hw/rtl/impact_detector_logger.sv
sim/shock_log_checker.sv
sim/impact_detector_logger_test.sv
